// File: sv/idr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU dead-reckoning integrator package
// Shared widths, constants and beat types for the integrator block.
// ----------------------------------------------------------------------------
package idr_pkg;

  localparam int QUAT_W      = 16;
  localparam int TIME_W      = 32;
  localparam int ACC_W       = 18;
  localparam int VEL_W       = 32;
  localparam int POS_W       = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int VEL_SHIFT   = 14;
  localparam int POS_SHIFT   = 20;
  localparam int ROT_SHIFT   = 27;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_VEL_X = 3'd0,
    CFG_INIT_VEL_Y = 3'd1,
    CFG_INIT_VEL_Z = 3'd2,
    CFG_INIT_POS_X = 3'd3,
    CFG_INIT_POS_Y = 3'd4,
    CFG_INIT_POS_Z = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [TIME_W-1:0]        sample_time;
    logic signed [QUAT_W-1:0] accel_x;
    logic signed [QUAT_W-1:0] accel_y;
    logic signed [QUAT_W-1:0] accel_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
  } sample_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    saturated;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_t;

  // Classified sample as handed from the front end to the back end.
  typedef struct packed {
    logic                     first;
    logic [TIME_W-1:0]        dt;
    logic signed [QUAT_W-1:0] accel_x;
    logic signed [QUAT_W-1:0] accel_y;
    logic signed [QUAT_W-1:0] accel_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
  } job_t;

  typedef struct packed {
    logic [2:0][VEL_W-1:0] vel;
    logic [2:0][POS_W-1:0] pos;
  } init_t;

endpackage

// File: sv/idr_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// One beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface idr_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/idr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrator front end
// Accepts samples, tags the first one after reset and forms the time step.
// ----------------------------------------------------------------------------
module idr_front
  import idr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  idr_chan_if.sink   sample_i,
  idr_chan_if.source job_o
);

  logic              seen_q;
  logic [TIME_W-1:0] prev_time_q;
  logic              accept;

  assign accept = sample_i.valid && sample_i.ready;

  always_comb begin
    sample_i.ready     = job_o.ready;
    job_o.valid        = sample_i.valid;
    job_o.data.first   = !seen_q;
    // The difference wraps, so a time stamp going backwards is a long step.
    job_o.data.dt      = sample_i.data.sample_time - prev_time_q;
    job_o.data.accel_x = sample_i.data.accel_x;
    job_o.data.accel_y = sample_i.data.accel_y;
    job_o.data.accel_z = sample_i.data.accel_z;
    job_o.data.quat_w  = sample_i.data.quat_w;
    job_o.data.quat_x  = sample_i.data.quat_x;
    job_o.data.quat_y  = sample_i.data.quat_y;
    job_o.data.quat_z  = sample_i.data.quat_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      prev_time_q <= '0;
    end else if (accept) begin
      seen_q      <= 1'b1;
      prev_time_q <= sample_i.data.sample_time;
    end
  end

endmodule

// File: sv/idr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module idr_queue
  import idr_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  idr_chan_if.sink   in_i,
  idr_chan_if.source out_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  always_comb begin
    in_i.ready  = (count_q != CntW'(Depth));
    out_o.valid = (count_q != '0);
    out_o.data  = mem_q[rd_ptr_q];
  end

  assign push = in_i.valid && in_i.ready;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: sv/idr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrator back end
// Rotates the acceleration into the world frame and integrates, one axis a
// step, behind a registered result stage.
// ----------------------------------------------------------------------------
module idr_back
  import idr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  init_t      init_i,
  idr_chan_if.sink   job_i,
  idr_chan_if.source result_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QPROD,
    ST_QMAT,
    ST_LOOP,
    ST_EMIT
  } state_e;

  // Quaternion product slots.
  localparam int QXX = 0;
  localparam int QYY = 1;
  localparam int QZZ = 2;
  localparam int QXY = 3;
  localparam int QXZ = 4;
  localparam int QYZ = 5;
  localparam int QWX = 6;
  localparam int QWY = 7;
  localparam int QWZ = 8;

  localparam int RM_W  = 2 * QUAT_W + 1;
  localparam int RP_W  = RM_W + QUAT_W;
  localparam int SUM_W = RP_W + 2;
  localparam int SH_W  = SUM_W - ROT_SHIFT;
  localparam int DT_W  = TIME_W + 1;
  localparam int PV_W  = VEL_W + DT_W + 1;
  localparam int PA_W  = ACC_W + DT_W;
  localparam int PS_W  = POS_W + 2;
  localparam int VS_W  = VEL_W + 6;

  localparam logic signed [RM_W-1:0]  ROT_ONE   = RM_W'(1) << ROT_SHIFT;
  localparam logic signed [SUM_W-1:0] ROT_ROUND = SUM_W'(1) << (ROT_SHIFT - 1);

  state_e state_q;
  logic [1:0] cnt_q;
  logic       sat_q;
  logic       out_valid_q;
  result_t    out_q;

  job_t                    job_q;
  logic signed [2*QUAT_W-1:0] qp_q [9];
  logic signed [2*QUAT_W-1:0] qp_d [9];
  logic signed [RM_W-1:0]  rm_q [3][3];
  logic signed [RM_W-1:0]  rm_d [3][3];
  logic signed [RP_W-1:0]  rp_q [3];
  logic signed [RP_W-1:0]  rp_d [3];
  logic signed [PV_W-1:0]  pv_q;
  logic signed [PV_W-1:0]  pv_d;
  logic signed [PA_W-1:0]  pa_q;
  logic signed [PA_W-1:0]  pa_d;
  logic signed [VEL_W-1:0] vel_q [3];
  logic signed [POS_W-1:0] pos_q [3];
  logic signed [ACC_W-1:0] acc_q [3];

  logic signed [QUAT_W-1:0] acc_in [3];
  logic signed [DT_W-1:0]   dt_s;
  logic [1:0]               mul_axis;
  logic [1:0]               cmt_axis;
  logic                     do_mul;
  logic                     do_cmt;
  logic signed [SUM_W-1:0]  world_sum;
  logic signed [SH_W-1:0]   world_sh;
  logic signed [ACC_W-1:0]  world_acc;
  logic signed [PS_W-1:0]   pos_sum;
  logic signed [VS_W-1:0]   vel_sum;
  logic signed [POS_W-1:0]  pos_new;
  logic signed [VEL_W-1:0]  vel_new;
  logic                     pos_ovf;
  logic                     vel_ovf;

  assign job_i.ready     = (state_q == ST_IDLE);
  assign result_o.valid  = out_valid_q;
  assign result_o.data   = out_q;

  assign acc_in[0] = job_q.accel_x;
  assign acc_in[1] = job_q.accel_y;
  assign acc_in[2] = job_q.accel_z;
  assign dt_s      = $signed({1'b0, job_q.dt});

  assign do_mul   = (state_q == ST_LOOP) && (cnt_q != 2'd3);
  assign do_cmt   = (state_q == ST_LOOP) && (cnt_q != 2'd0);
  assign mul_axis = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
  assign cmt_axis = (cnt_q == 2'd0) ? 2'd0 : cnt_q - 2'd1;

  // Quaternion products and the rotation matrix at half scale.
  always_comb begin
    qp_d[QXX] = job_q.quat_x * job_q.quat_x;
    qp_d[QYY] = job_q.quat_y * job_q.quat_y;
    qp_d[QZZ] = job_q.quat_z * job_q.quat_z;
    qp_d[QXY] = job_q.quat_x * job_q.quat_y;
    qp_d[QXZ] = job_q.quat_x * job_q.quat_z;
    qp_d[QYZ] = job_q.quat_y * job_q.quat_z;
    qp_d[QWX] = job_q.quat_w * job_q.quat_x;
    qp_d[QWY] = job_q.quat_w * job_q.quat_y;
    qp_d[QWZ] = job_q.quat_w * job_q.quat_z;

    rm_d[0][0] = ROT_ONE - (RM_W'(qp_q[QYY]) + RM_W'(qp_q[QZZ]));
    rm_d[0][1] = RM_W'(qp_q[QXY]) - RM_W'(qp_q[QWZ]);
    rm_d[0][2] = RM_W'(qp_q[QXZ]) + RM_W'(qp_q[QWY]);
    rm_d[1][0] = RM_W'(qp_q[QXY]) + RM_W'(qp_q[QWZ]);
    rm_d[1][1] = ROT_ONE - (RM_W'(qp_q[QXX]) + RM_W'(qp_q[QZZ]));
    rm_d[1][2] = RM_W'(qp_q[QYZ]) - RM_W'(qp_q[QWX]);
    rm_d[2][0] = RM_W'(qp_q[QXZ]) - RM_W'(qp_q[QWY]);
    rm_d[2][1] = RM_W'(qp_q[QYZ]) + RM_W'(qp_q[QWX]);
    rm_d[2][2] = ROT_ONE - (RM_W'(qp_q[QXX]) + RM_W'(qp_q[QYY]));
  end

  // Multiply step for one axis: a matrix row and the two integration terms.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rp_d[j] = rm_q[mul_axis][j] * acc_in[j];
    end
    pv_d = vel_q[mul_axis] * dt_s;
    pa_d = acc_q[mul_axis] * dt_s;
  end

  // Commit step for the axis multiplied in the cycle before.
  always_comb begin
    world_sum = SUM_W'(rp_q[0]) + SUM_W'(rp_q[1]) + SUM_W'(rp_q[2]) + ROT_ROUND;
    world_sh  = $signed(world_sum[SUM_W-1:ROT_SHIFT]);
    if ((&world_sh[SH_W-1:ACC_W-1]) || !(|world_sh[SH_W-1:ACC_W-1])) begin
      world_acc = world_sh[ACC_W-1:0];
    end else begin
      world_acc = world_sh[SH_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                   : {1'b0, {(ACC_W-1){1'b1}}};
    end

    pos_sum = PS_W'(pos_q[cmt_axis]) + PS_W'($signed(pv_q[PV_W-1:POS_SHIFT]));
    pos_ovf = !((&pos_sum[PS_W-1:POS_W-1]) || !(|pos_sum[PS_W-1:POS_W-1]));
    if (pos_ovf) begin
      pos_new = pos_sum[PS_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      pos_new = pos_sum[POS_W-1:0];
    end

    vel_sum = VS_W'(vel_q[cmt_axis]) + VS_W'($signed(pa_q[PA_W-1:VEL_SHIFT]));
    vel_ovf = !((&vel_sum[VS_W-1:VEL_W-1]) || !(|vel_sum[VS_W-1:VEL_W-1]));
    if (vel_ovf) begin
      vel_new = vel_sum[VS_W-1] ? {1'b1, {(VEL_W-1){1'b0}}}
                                : {1'b0, {(VEL_W-1){1'b1}}};
    end else begin
      vel_new = vel_sum[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_i.valid && job_i.ready) begin
      job_q <= job_i.data;
    end
    if (state_q == ST_QPROD) begin
      qp_q <= qp_d;
    end
    if (state_q == ST_QMAT) begin
      rm_q <= rm_d;
    end
    if (do_mul) begin
      rp_q <= rp_d;
      pv_q <= pv_d;
      pa_q <= pa_d;
    end
    if (do_cmt) begin
      acc_q[cmt_axis] <= world_acc;
      if (job_q.first) begin
        vel_q[cmt_axis] <= $signed(init_i.vel[cmt_axis]);
        pos_q[cmt_axis] <= $signed(init_i.pos[cmt_axis]);
      end else begin
        vel_q[cmt_axis] <= vel_new;
        pos_q[cmt_axis] <= pos_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 2'd0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // While a new result is being loaded the emit arm sets valid itself.
      if (out_valid_q && result_o.ready && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_i.valid) begin
            sat_q   <= 1'b0;
            state_q <= ST_QPROD;
          end
        end
        ST_QPROD: begin
          state_q <= ST_QMAT;
        end
        ST_QMAT: begin
          cnt_q   <= 2'd0;
          state_q <= ST_LOOP;
        end
        ST_LOOP: begin
          if (do_cmt && !job_q.first && (pos_ovf || vel_ovf)) begin
            sat_q <= 1'b1;
          end
          if (cnt_q == 2'd3) begin
            state_q <= ST_EMIT;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || result_o.ready) begin
            out_valid_q     <= 1'b1;
            out_q.vel_x     <= vel_q[0];
            out_q.vel_y     <= vel_q[1];
            out_q.vel_z     <= vel_q[2];
            out_q.pos_x     <= pos_q[0];
            out_q.pos_y     <= pos_q[1];
            out_q.pos_z     <= pos_q[2];
            out_q.saturated <= sat_q;
            state_q         <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/imu_dead_reckoning_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU dead-reckoning integrator
// Rotates body acceleration into the world frame and double-integrates it.
// ----------------------------------------------------------------------------
//  Channel    Dir   Beat
//  sample_i   in    time stamp, body acceleration, orientation quaternion
//  result_o   out   world velocity, world position, saturation flag
//  cfg_i      in    register index and write data for the initial state
//
// A sample passes through the back end in steps: fetch from the job queue,
// the quaternion products, the rotation matrix, four per-axis multiply and
// commit steps and the load of the result. The single sequencer takes no new
// sample until that result is loaded. The queue lets samples arrive while the
// sequencer is busy, and the result register lets a result wait for the sink.
// Reset clears the initial-state registers to zero and marks the next sample
// as the first one.
module imu_dead_reckoning_integrator
  import idr_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  idr_chan_if.sink   sample_i,
  idr_chan_if.source result_o,
  idr_chan_if.sink   cfg_i
);

  init_t init_q;

  idr_chan_if #(.T(job_t)) front_job ();
  idr_chan_if #(.T(job_t)) back_job ();

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CFG_INIT_VEL_X: init_q.vel[0] <= cfg_i.data.wdata[VEL_W-1:0];
        CFG_INIT_VEL_Y: init_q.vel[1] <= cfg_i.data.wdata[VEL_W-1:0];
        CFG_INIT_VEL_Z: init_q.vel[2] <= cfg_i.data.wdata[VEL_W-1:0];
        CFG_INIT_POS_X: init_q.pos[0] <= cfg_i.data.wdata[POS_W-1:0];
        CFG_INIT_POS_Y: init_q.pos[1] <= cfg_i.data.wdata[POS_W-1:0];
        CFG_INIT_POS_Z: init_q.pos[2] <= cfg_i.data.wdata[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  idr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .job_o    (front_job)
  );

  idr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (front_job),
    .out_o  (back_job)
  );

  idr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .init_i   (init_q),
    .job_i    (back_job),
    .result_o (result_o)
  );

endmodule
